// File: rtl/core/rtd_pkg.sv
`default_nettype none

package rtd_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_OPAQUE_COUNT = 2'd0;
  localparam logic [1:0] PH_COLOURS      = 2'd1;
  localparam logic [1:0] PH_TRANSP_COUNT = 2'd2;

  // Count byte value that marks the end of a row
  localparam logic [7:0] ROW_END = 8'hFF;

  // Result kinds
  localparam logic KIND_OPAQUE = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  localparam int CFG_W = 17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } item_t;

  typedef struct packed {
    logic        run_kind;
    logic [15:0] pixel_index;
    logic [7:0]  color_index;
    logic [7:0]  run_length;
    logic        image_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/rle_transparent_bitmap_decoder.sv
// An accepted byte waits in the input register; its result, if any, is registered when taken.
// Throughput: one byte per cycle; the parser state updates in a single step.
// A full result register stalls the input only while out_ready is low.
// Synchronous active-low reset clears the parser (expect opaque count,
// no colour bytes left, pixel zero), sets the image size to 1, and empties both stages.
`default_nettype none

module rle_transparent_bitmap_decoder
  import rtd_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_image_start,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_run_kind,
  output logic [15:0]           out_pixel_index,
  output logic [7:0]            out_color_index,
  output logic [7:0]            out_run_length,
  output logic                  out_image_done,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Largest limit that the size register can reach
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int LIM_MAX = (MAX_PIXELS < CFG_MAX) ? MAX_PIXELS : CFG_MAX;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);

  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [31:0]      cfg_ext;
  item_t            in_item;
  item_t            item;
  logic             item_valid;
  logic             take;
  result_t          result;

  // Clamp the image size once, at write time
  always_comb begin
    cfg_ext = 32'(cfg_wdata);
    if (cfg_ext == 32'd0) begin
      limit_nxt = CNT_W'(1);
    end else if (cfg_ext > 32'(LIM_MAX)) begin
      limit_nxt = CNT_W'(LIM_MAX);
    end else begin
      limit_nxt = CNT_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CNT_W'(1);
    end else if (cfg_we) begin
      limit_r <= limit_nxt;
    end
  end

  assign in_item.data_byte   = in_data_byte;
  assign in_item.image_start = in_image_start;

  rtd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rtd_parse #(
    .CNT_W (CNT_W)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .limit      (limit_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign out_run_kind    = result.run_kind;
  assign out_pixel_index = result.pixel_index;
  assign out_color_index = result.color_index;
  assign out_run_length  = result.run_length;
  assign out_image_done  = result.image_done;

endmodule

`default_nettype wire

// File: rtl/core/rtd_in_stage.sv
`default_nettype none

module rtd_in_stage
  import rtd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Accept a new request when the buffer is empty or drains this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until the next request is taken
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: rtl/core/rtd_parse.sv
`default_nettype none

module rtd_parse
  import rtd_pkg::*;
#(
  parameter int CNT_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire item_t            item,
  output logic                  take,
  input  wire logic [CNT_W-1:0] limit,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               result
);

  localparam int EW = CNT_W + 9;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [CNT_W-1:0] next_pixel_r, next_pixel_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          result_r, result_nxt;

  logic [1:0]       ph;
  logic [7:0]       bl;
  logic [7:0]       bl_dec;
  logic [EW-1:0]    np0_w, np_w, lim_w, b_w, room_w, len_w, sum_w, np_inc_w;
  logic [31:0]      idx_ext;
  logic             room_left;
  logic             emit;

  // Move an item into the result stage whenever the result register is free or is being taken downstream
  assign take = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    // Start of image clears the parser before the byte is used
    ph     = item.image_start ? PH_OPAQUE_COUNT : phase_r;
    bl     = item.image_start ? 8'd0 : bytes_left_r;
    np0_w  = item.image_start ? '0 : EW'(next_pixel_r);
    lim_w  = EW'(limit);
    np_w   = (np0_w > lim_w) ? lim_w : np0_w;
    b_w    = EW'(item.data_byte);
    room_w = lim_w - np_w;
    len_w  = (b_w < room_w) ? b_w : room_w;
    sum_w  = np_w + b_w;
    np_inc_w  = np_w + EW'(1);
    bl_dec    = bl - 8'd1;
    room_left = (np_w < lim_w);
    idx_ext   = 32'(np_w);

    phase_nxt      = ph;
    bytes_left_nxt = bl;
    next_pixel_nxt = CNT_W'(np_w);
    emit           = 1'b0;

    result_nxt.run_kind    = KIND_OPAQUE;
    result_nxt.pixel_index = idx_ext[15:0];
    result_nxt.color_index = item.data_byte;
    result_nxt.run_length  = 8'd1;
    result_nxt.image_done  = (np_inc_w == lim_w);

    case (ph)
      PH_COLOURS: begin
        if (room_left) begin
          emit           = 1'b1;
          next_pixel_nxt = CNT_W'(np_inc_w);
        end
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          phase_nxt = PH_TRANSP_COUNT;
        end
      end
      PH_TRANSP_COUNT: begin
        result_nxt.run_kind    = KIND_RUN;
        result_nxt.color_index = 8'd0;
        result_nxt.run_length  = len_w[7:0];
        result_nxt.image_done  = (len_w == room_w);
        if (item.data_byte != ROW_END) begin
          emit           = (item.data_byte != 8'd0) && room_left;
          next_pixel_nxt = CNT_W'((sum_w > lim_w) ? lim_w : sum_w);
        end
        phase_nxt = PH_OPAQUE_COUNT;
      end
      default: begin
        // Opaque count; a row-end marker keeps waiting for a count
        phase_nxt = PH_OPAQUE_COUNT;
        if (item.data_byte != ROW_END) begin
          bytes_left_nxt = item.data_byte;
          phase_nxt = (item.data_byte == 8'd0) ? PH_TRANSP_COUNT : PH_COLOURS;
        end
      end
    endcase
  end

  // Advance the parser state on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OPAQUE_COUNT;
      bytes_left_r <= 8'd0;
      next_pixel_r <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      next_pixel_r <= next_pixel_nxt;
    end
  end

  // Result register: load on an emitting item, drop when taken downstream
  assign out_valid_nxt = take ? emit : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// File: rtl/core/rtd_checker.sv
`default_nettype none

module rtd_checker
  import rtd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_run_kind,
  input wire logic [15:0]      out_pixel_index,
  input wire logic [7:0]       out_color_index,
  input wire logic [7:0]       out_run_length,
  input wire logic             out_image_done
);

  // A stalled result holds steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index)
      && $stable(out_run_kind) && $stable(out_run_length)
      && $stable(out_color_index) && $stable(out_image_done))
    else $error("result changed while stalled");

  // An opaque pixel covers exactly one pixel
  a_opaque_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_kind == KIND_OPAQUE |-> out_run_length == 8'd1)
    else $error("opaque pixel with length other than one");

  // A transparent run is nonempty, not a row-end marker, and has no colour
  a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_kind == KIND_RUN |->
      out_color_index == 8'd0 && out_run_length != 8'd0 && out_run_length != ROW_END)
    else $error("malformed transparent run");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rle_transparent_bitmap_decoder rtd_checker u_rtd_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rtd_pkg::*;

  localparam int MAX_PIXELS = 65536;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte   = 8'd0;
  logic             in_image_start = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b1;
  logic             out_run_kind;
  logic [15:0]      out_pixel_index;
  logic [7:0]       out_color_index;
  logic [7:0]       out_run_length;
  logic             out_image_done;
  logic             cfg_we         = 1'b0;
  logic [CFG_W-1:0] cfg_wdata      = '0;

  rle_transparent_bitmap_decoder #(
    .MAX_PIXELS(MAX_PIXELS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_run_kind   (out_run_kind),
    .out_pixel_index(out_pixel_index),
    .out_color_index(out_color_index),
    .out_run_length (out_run_length),
    .out_image_done (out_image_done),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // Requests waiting to be sent and results waiting to arrive
  item_t   pending_bytes[$];
  result_t expected_pixels[$];
  int      bytes_queued = 0;
  int      errors = 0;

  // Decoder state as the testbench sees it
  logic [CFG_W-1:0] image_size = CFG_W'(1);
  logic [1:0]       parse_phase = PH_OPAQUE_COUNT;
  logic [7:0]       colours_left = 8'd0;
  int               pixel_pos = 0;

  // Sender and receiver pacing
  item_t       drive_item;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age = 0;
  result_t     oldest_pixel;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the result, if any, that one accepted byte causes
  function automatic void decode_byte(input logic [7:0] b, input logic img_start);
    int      lim;
    int      room;
    int      len;
    result_t r;
    lim = int'(image_size);
    if (lim < 1) lim = 1;
    if (lim > MAX_PIXELS) lim = MAX_PIXELS;
    if (img_start) begin
      parse_phase  = PH_OPAQUE_COUNT;
      colours_left = 8'd0;
      pixel_pos    = 0;
    end
    if (pixel_pos > lim) pixel_pos = lim;
    case (parse_phase)
      PH_COLOURS: begin
        if (pixel_pos < lim) begin
          r.run_kind    = KIND_OPAQUE;
          r.pixel_index = 16'(pixel_pos);
          r.color_index = b;
          r.run_length  = 8'd1;
          r.image_done  = (pixel_pos + 1 == lim);
          expected_pixels.push_back(r);
          pixel_pos++;
        end
        colours_left = colours_left - 8'd1;
        if (colours_left == 8'd0) parse_phase = PH_TRANSP_COUNT;
      end
      PH_TRANSP_COUNT: begin
        if (b != ROW_END && b != 8'd0 && pixel_pos < lim) begin
          room = lim - pixel_pos;
          len  = (int'(b) < room) ? int'(b) : room;
          r.run_kind    = KIND_RUN;
          r.pixel_index = 16'(pixel_pos);
          r.color_index = 8'd0;
          r.run_length  = 8'(len);
          r.image_done  = (len == room);
          expected_pixels.push_back(r);
        end
        if (b != ROW_END) begin
          pixel_pos += int'(b);
          if (pixel_pos > lim) pixel_pos = lim;
        end
        parse_phase = PH_OPAQUE_COUNT;
      end
      default: begin
        parse_phase = PH_OPAQUE_COUNT;
        if (b != ROW_END) begin
          colours_left = b;
          parse_phase  = (b == 8'd0) ? PH_TRANSP_COUNT : PH_COLOURS;
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic img_start);
    item_t it;
    it.data_byte   = b;
    it.image_start = img_start;
    pending_bytes.push_back(it);
    bytes_queued++;
  endfunction

  // Queue one coded image; long runs fill large images with few bytes
  task automatic queue_image(input int size_px, input bit long_runs);
    int covered;
    int n;
    int t;
    bit first;
    bit cut;
    covered = 0;
    first   = 1'b1;
    cut     = ($urandom_range(0, 9) == 0);
    while (covered < size_px) begin
      // drop the rest of the image now and then
      if (cut && !first && $urandom_range(0, 3) == 0) break;
      if ($urandom_range(0, 7) == 0) begin
        queue_byte(ROW_END, first);
        first = 1'b0;
      end
      if (long_runs) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      end else begin
        case ($urandom_range(0, 49))
          0:       n = $urandom_range(128, 254);
          1, 2, 3: n = $urandom_range(7, 30);
          4, 5, 6: n = 0;
          default: n = $urandom_range(1, 6);
        endcase
      end
      queue_byte(8'(n), first);
      first = 1'b0;
      repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      if (long_runs) begin
        t = ($urandom_range(0, 15) == 0) ? int'(ROW_END) : $urandom_range(200, 254);
      end else begin
        case ($urandom_range(0, 11))
          0:       t = int'(ROW_END);
          1:       t = 0;
          2:       t = $urandom_range(100, 254);
          default: t = $urandom_range(1, 12);
        endcase
      end
      queue_byte(8'(t), 1'b0);
      covered += n;
      if (t != int'(ROW_END)) covered += t;
    end
    // bytes past the end of a full image
    if (!cut && $urandom_range(0, 3) == 0) begin
      queue_byte(8'd2, 1'b0);
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      queue_byte(8'($urandom_range(1, 254)), 1'b0);
    end
  endtask

  // Hold until every request is sent and every result is back
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input int px);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(px);
    @(posedge clk);
    cfg_we    <= 1'b0;
    image_size = CFG_W'(px);
  endtask

  // Send requests in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0 || pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        drive_item = pending_bytes.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= drive_item.data_byte;
        in_image_start <= drive_item.image_start;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) decode_byte(in_data_byte, in_image_start);
  end

  // Stall the result side on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pattern_age == 63) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0001);
      pattern_age   <= 0;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age + 1;
    end
    out_ready <= ready_pattern[0];
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d index %0d",
                 $time, out_run_kind, out_pixel_index);
        errors++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        compare_field("run_kind", oldest_pixel.run_kind, out_run_kind);
        compare_field("pixel_index", oldest_pixel.pixel_index, out_pixel_index);
        compare_field("color_index", oldest_pixel.color_index, out_color_index);
        compare_field("run_length", oldest_pixel.run_length, out_run_length);
        compare_field("image_done", oldest_pixel.image_done, out_image_done);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL rle_transparent_bitmap_decoder");
    $finish;
  end

  initial begin
    int px;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset image size of one: first pixel finishes the image
    queue_byte(8'd1, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'd3, 1'b0);
    wait_idle();

    // Row-end markers, zero counts, colour extremes, run clipped at the end
    write_size(10);
    queue_byte(ROW_END, 1'b1);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'd2, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ROW_END, 1'b0);
    queue_byte(8'd3, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'd254, 1'b0);
    queue_byte(8'd1, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'd4, 1'b0);
    wait_idle();

    // Size zero counts as one
    write_size(0);
    queue_byte(8'd1, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'd1, 1'b0);
    wait_idle();

    // Size above the cap, then shrunk mid-image below the position
    write_size((1 << CFG_W) - 1);
    queue_byte(8'd0, 1'b1);
    queue_byte(8'd254, 1'b0);
    wait_idle();
    write_size(100);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'd254, 1'b0);
    wait_idle();

    // One large image made mostly of long runs, reaching the top index bit
    write_size(36000);
    queue_image(36000, 1'b1);
    wait_idle();

    // Random phases of small images and noise
    while (bytes_queued < 650) begin
      case ($urandom_range(0, 9))
        0:       px = 1;
        1:       px = 2;
        2:       px = $urandom_range(61, 300);
        default: px = $urandom_range(3, 60);
      endcase
      write_size(px);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 8))
            queue_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end else begin
          queue_image(px, 1'b0);
        end
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS rle_transparent_bitmap_decoder");
    end else begin
      $display("FAIL rle_transparent_bitmap_decoder");
    end
    $finish;
  end

endmodule
